@@ src/slm_pkg.sv @@
// slm_pkg: shared types and constants for the sorted list merge block
// holds the operation codes, the queued command format and the back-end states
// no dependencies
package slm_pkg;

    // width of one element
    localparam int unsigned VALUE_W = 32;
    // width of the func selector on the input stream
    localparam int unsigned FUNC_W  = 2;

    // command queue between front and back
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QAW     = 2;
    localparam int unsigned QCW     = 3;

    // func codes as they arrive on the input stream
    localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP      = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd3;

    // classified operation
    typedef enum logic [1:0] {
        OP_APPEND_A,
        OP_APPEND_B,
        OP_POP,
        OP_CLEAR
    } t_op;

    // one queued command
    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    // back-end sequencer states
    typedef enum logic {
        S_IDLE,
        S_MERGE
    } t_state;

endpackage

@@ src/slm_front.sv @@
// slm_front: input side of the sorted list merge block
// accepts stream transactions, classifies func into an operation, queues commands
// depends on slm_pkg
module slm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [slm_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [slm_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_cmd_valid,
    output slm_pkg::t_cmd                       o_cmd,
    input  logic                                i_deq
);

    slm_pkg::t_cmd                  r_queue [slm_pkg::QDEPTH];
    logic [slm_pkg::QAW-1:0]        r_wr_ptr;
    logic [slm_pkg::QAW-1:0]        r_rd_ptr;
    logic [slm_pkg::QCW-1:0]        r_count;
    logic [slm_pkg::QCW-1:0]        n_count;
    slm_pkg::t_cmd                  new_cmd;
    logic                           enq;

    // classify the incoming func code
    always_comb begin
        new_cmd.value = i_value;
        case (i_func)
            slm_pkg::FUNC_APPEND_A: new_cmd.op = slm_pkg::OP_APPEND_A;
            slm_pkg::FUNC_APPEND_B: new_cmd.op = slm_pkg::OP_APPEND_B;
            slm_pkg::FUNC_POP:      new_cmd.op = slm_pkg::OP_POP;
            slm_pkg::FUNC_CLEAR:    new_cmd.op = slm_pkg::OP_CLEAR;
            default:                new_cmd.op = slm_pkg::OP_CLEAR;
        endcase
    end

    assign o_ready     = (r_count != slm_pkg::QCW'(slm_pkg::QDEPTH));
    assign enq         = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    // occupancy update
    always_comb begin
        n_count = r_count;
        case ({enq, i_deq})
            2'b10:   n_count = r_count + slm_pkg::QCW'(1);
            2'b01:   n_count = r_count - slm_pkg::QCW'(1);
            default: n_count = r_count;
        endcase
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (enq) begin
                r_wr_ptr <= r_wr_ptr + slm_pkg::QAW'(1);
            end
            if (i_deq) begin
                r_rd_ptr <= r_rd_ptr + slm_pkg::QAW'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_queue[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

@@ src/slm_back.sv @@
// slm_back: execution side of the sorted list merge block
// holds both list memories, counts and heads, runs the merge and the result register
// depends on slm_pkg
module slm_back #(
    parameter int unsigned DEPTH_A = 256,
    parameter int unsigned DEPTH_B = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    input  slm_pkg::t_cmd                       i_cmd,
    output logic                                o_deq,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [slm_pkg::VALUE_W-1:0]  o_value,
    output logic                                o_from_b,
    output logic                                o_last,
    output logic                                o_empty
);

    localparam int unsigned AW_A = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
    localparam int unsigned AW_B = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
    localparam int unsigned CW_A = $clog2(DEPTH_A + 1);
    localparam int unsigned CW_B = $clog2(DEPTH_B + 1);

    logic signed [slm_pkg::VALUE_W-1:0] mem_a [DEPTH_A];
    logic signed [slm_pkg::VALUE_W-1:0] mem_b [DEPTH_B];
    logic signed [slm_pkg::VALUE_W-1:0] r_rd_a;
    logic signed [slm_pkg::VALUE_W-1:0] r_rd_b;

    slm_pkg::t_state r_state, n_state;
    logic [CW_A-1:0] r_cnt_a, n_cnt_a, r_head_a, n_head_a;
    logic [CW_B-1:0] r_cnt_b, n_cnt_b, r_head_b, n_head_b;

    logic                               r_out_valid, n_out_valid;
    logic signed [slm_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    logic                               r_out_from_b, n_out_from_b;
    logic                               r_out_last, n_out_last;
    logic                               r_out_empty, n_out_empty;

    logic wr_a, wr_b;
    logic have_a, have_b, take_b, out_free;

    assign have_a   = (r_head_a < r_cnt_a);
    assign have_b   = (r_head_b < r_cnt_b);
    assign out_free = !r_out_valid || i_ready;

    // signed head compare, a wins ties
    always_comb begin
        if (have_a && have_b) begin
            take_b = !(r_rd_a <= r_rd_b);
        end else begin
            take_b = have_b;
        end
    end

    // sequencer: next state, pointers and result load
    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_head_a     = r_head_a;
        n_head_b     = r_head_b;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_value  = r_out_value;
        n_out_from_b = r_out_from_b;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        wr_a         = 1'b0;
        wr_b         = 1'b0;
        o_deq        = 1'b0;
        case (r_state)
            slm_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        slm_pkg::OP_APPEND_A: begin
                            o_deq = 1'b1;
                            if (r_cnt_a != CW_A'(DEPTH_A)) begin
                                wr_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CW_A'(1);
                            end
                        end
                        slm_pkg::OP_APPEND_B: begin
                            o_deq = 1'b1;
                            if (r_cnt_b != CW_B'(DEPTH_B)) begin
                                wr_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CW_B'(1);
                            end
                        end
                        slm_pkg::OP_CLEAR: begin
                            o_deq    = 1'b1;
                            n_cnt_a  = '0;
                            n_cnt_b  = '0;
                            n_head_a = '0;
                            n_head_b = '0;
                        end
                        slm_pkg::OP_POP: begin
                            if (!have_a && !have_b) begin
                                // both lists used up: empty result
                                if (out_free) begin
                                    o_deq        = 1'b1;
                                    n_out_valid  = 1'b1;
                                    n_out_value  = '0;
                                    n_out_from_b = 1'b0;
                                    n_out_last   = 1'b0;
                                    n_out_empty  = 1'b1;
                                end
                            end else begin
                                // heads are read this cycle
                                n_state = slm_pkg::S_MERGE;
                            end
                        end
                        default: begin
                            o_deq = 1'b1;
                        end
                    endcase
                end
            end
            slm_pkg::S_MERGE: begin
                if (out_free) begin
                    o_deq        = 1'b1;
                    n_state      = slm_pkg::S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_from_b = take_b;
                    n_out_empty  = 1'b0;
                    if (take_b) begin
                        n_head_b    = r_head_b + CW_B'(1);
                        n_out_value = r_rd_b;
                    end else begin
                        n_head_a    = r_head_a + CW_A'(1);
                        n_out_value = r_rd_a;
                    end
                    n_out_last = (n_head_a >= r_cnt_a) && (n_head_b >= r_cnt_b);
                end
            end
            default: begin
                n_state = slm_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slm_pkg::S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_head_a    <= '0;
            r_head_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_head_a    <= n_head_a;
            r_head_b    <= n_head_b;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_from_b <= n_out_from_b;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
    end

    // list a memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[r_cnt_a[AW_A-1:0]] <= i_cmd.value;
        end
        r_rd_a <= mem_a[r_head_a[AW_A-1:0]];
    end

    // list b memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[r_cnt_b[AW_B-1:0]] <= i_cmd.value;
        end
        r_rd_b <= mem_b[r_head_b[AW_B-1:0]];
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_from_b = r_out_from_b;
    assign o_last   = r_out_last;
    assign o_empty  = r_out_empty;

endmodule

@@ src/sorted_list_merge.sv @@
// sorted_list_merge: two-way merge of two ascending lists of signed 32-bit values
// top level; instantiates slm_front and slm_back, depends on slm_pkg
//
// usage:
//   input stream (i_s_*): tuser carries func (0 append a, 1 append b, 2 pop,
//   3 clear), tdata carries the element value. a transaction completes when
//   tvalid and tready are both high. appends to a full list are dropped.
//   output stream (o_m_*): one transaction per pop. tdata is the merged value,
//   tuser[0] says it came from list b, tuser[1] says both lists were already
//   used up, tlast marks the final element of the merge.
// sequencing:
//   a 4-entry command queue parts the input side from the merge sequencer.
//   append and clear are retired straight from idle, as is a pop of an exhausted
//   merge; a pop that returns an element passes through the merge state (heads
//   are fetched through the registered read ports of the two list memories).
//   every result leaves from a registered output stage.
// reset: synchronous, active low; clears counts, heads, queue and output valid.
//   list memories are not cleared.
// stall: while the output is held, commands keep queuing until the queue fills,
//   then i_s_tready drops.
module sorted_list_merge #(
    parameter int unsigned DEPTH_A = 256,
    parameter int unsigned DEPTH_B = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] value_out
    output logic [1:0]  o_m_tuser,   // [0] from_b, [1] empty_res
    output logic        o_m_tlast    // last
);

    logic          cmd_valid;
    slm_pkg::t_cmd cmd;
    logic          deq;
    logic signed [slm_pkg::VALUE_W-1:0] out_value;
    logic          out_from_b;
    logic          out_empty;

    // input side and command queue
    slm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_func      (i_s_tuser),
        .i_value     ($signed(i_s_tdata)),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_deq       (deq)
    );

    // list storage and merge
    slm_back #(
        .DEPTH_A (DEPTH_A),
        .DEPTH_B (DEPTH_B)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_deq       (deq),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_value     (out_value),
        .o_from_b    (out_from_b),
        .o_last      (o_m_tlast),
        .o_empty     (out_empty)
    );

    assign o_m_tdata = out_value;
    assign o_m_tuser = {out_empty, out_from_b};

    // the sequencer only retires commands that are present
    a_deq_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq |-> cmd_valid)
        else $error("command retired from an empty queue");

    // a new result only follows a retired pop
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(deq && cmd.op == slm_pkg::OP_POP))
        else $error("result without a pop");

    // an empty result carries no element
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata == '0 && !o_m_tuser[0] && !o_m_tlast))
        else $error("empty result carries data");

endmodule
